/* rtl/ucs_pkg.sv */
// Package: shared types and constants for the UCT child selector.
`default_nettype none
package ucs_pkg;
    localparam int MAX_CHILDREN = 256;
    localparam int POS_W = $clog2(MAX_CHILDREN + 1);
    localparam int KEY_W = 50;
    localparam logic [KEY_W-1:0] KEY_PLUS_INF = {KEY_W{1'b1}};
    localparam logic [15:0] LN2_Q16 = 16'd45426;
    localparam logic [15:0] GAIN_RESET = 16'd5793;
    localparam logic [1:0] MODE_UCT = 2'd0;
    localparam logic [1:0] MODE_RATIO = 2'd1;
    localparam logic [0:0] REG_MODE = 1'b0;
    localparam logic [0:0] REG_GAIN = 1'b1;

    typedef struct packed {
        logic        side;
        logic [31:0] parent_visits;
        logic [31:0] child_score_side0;
        logic [31:0] child_score_side1;
        logic [31:0] child_visits;
        logic        last_child;
    } t_in_item;

    typedef struct packed {
        logic [7:0] chosen_index;
        logic       chosen_unvisited;
    } t_out_item;

    // Classified work handed from the front to the back.
    typedef struct packed {
        logic        first;
        logic        scored;
        logic        last;
        logic [1:0]  mode;
        logic [31:0] parent;
        logic [31:0] score;
        logic [31:0] visits;
        logic [7:0]  pos;
    } t_job;
endpackage
`default_nettype wire

/* rtl/ucs_front.sv */
// Front end: accepts items, latches side and tracks position in the run.
`default_nettype none
module ucs_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ucs_pkg::t_in_item i_item,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire logic [1:0]       i_mode,
    output ucs_pkg::t_job         o_job,
    output logic                  o_job_valid,
    input  wire logic             i_job_ready
);
    import ucs_pkg::*;
    logic [POS_W-1:0] r_pos;
    logic             r_side;
    logic             w_side;
    logic             w_acc;

    assign o_full = ~i_job_ready;
    assign w_acc = i_push & i_job_ready;
    assign w_side = (r_pos == '0) ? i_item.side : r_side;
    assign o_job_valid = i_push;

    always_comb begin
        o_job.first = (r_pos == '0);
        o_job.scored = (r_pos < POS_W'(MAX_CHILDREN));
        o_job.last = i_item.last_child;
        o_job.mode = i_mode;
        o_job.parent = i_item.parent_visits;
        o_job.score = w_side ? i_item.child_score_side1 : i_item.child_score_side0;
        o_job.visits = i_item.child_visits;
        o_job.pos = r_pos[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_side <= 1'b0;
        end else if (w_acc) begin
            r_side <= w_side;
            if (i_item.last_child) r_pos <= '0;
            else if (r_pos < POS_W'(MAX_CHILDREN)) r_pos <= r_pos + 1'b1;
        end
    end
endmodule
`default_nettype wire

/* rtl/ucs_queue.sv */
// Two-entry job queue between front and back.
`default_nettype none
module ucs_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ucs_pkg::t_job i_job,
    input  wire logic          i_valid,
    output logic               o_ready,
    output ucs_pkg::t_job      o_job,
    output logic               o_valid,
    input  wire logic          i_ready
);
    import ucs_pkg::*;
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job = r_mem[r_rp];
    assign w_wr = i_valid & o_ready;
    assign w_rd = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end
endmodule
`default_nettype wire

/* rtl/ucs_back.sv */
// Back end: iterative ln, divides, sqrt, compare and result register.
`default_nettype none
module ucs_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ucs_pkg::t_job  i_job,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [15:0]    i_gain,
    output ucs_pkg::t_out_item  o_item,
    output logic                o_empty,
    input  wire logic           i_pop
);
    import ucs_pkg::*;
    localparam logic [3:0] S_IDLE = 4'd0, S_LNK = 4'd1, S_LNSQ = 4'd2, S_LNMUL = 4'd3,
                           S_DIV1 = 4'd4, S_DIV2 = 4'd5, S_SQRT = 4'd6, S_MUL = 4'd7,
                           S_CMP = 4'd8, S_OUT = 4'd9;
    logic [3:0]  r_st, n_st;
    t_job        r_job;
    logic [KEY_W-1:0] r_best;
    logic [7:0]  r_bpos;
    logic        r_bunv, r_inf;
    logic [31:0] r_ln;
    logic [4:0]  r_k;
    logic [32:0] r_x;
    logic [15:0] r_frac;
    logic [5:0]  r_cnt;
    logic [47:0] r_q;
    logic [32:0] r_rem;
    logic [47:0] r_num;
    logic [47:0] r_ratio;
    logic [47:0] r_sv;
    logic [23:0] r_root;
    logic [49:0] r_sacc;
    logic [KEY_W-1:0] r_key;
    logic        r_ovalid;
    t_out_item   r_out;

    logic [65:0] w_sq;
    logic [32:0] w_xn;
    logic [20:0] w_l2;
    logic [36:0] w_lnp;
    logic [33:0] w_rs;
    logic [49:0] w_trial;
    logic [39:0] w_ex;
    logic [KEY_W-1:0] w_ckey;
    logic        w_unv;
    logic [4:0]  w_k;

    assign o_ready = (r_st == S_IDLE);
    assign o_empty = ~r_ovalid;
    assign o_item = r_out;
    assign w_sq = {33'd0, r_x} * {33'd0, r_x};
    assign w_xn = w_sq[63:31];
    assign w_l2 = {r_k, r_frac};
    assign w_lnp = {16'd0, w_l2} * {21'd0, LN2_Q16};
    assign w_rs = {r_rem, r_num[47]} - {2'b0, r_job.visits};
    assign w_trial = {r_sacc[47:0], r_sv[47:46]} - {24'd0, r_root, 2'b01};
    assign w_ex = {8'd0, i_gain} * {16'd0, r_root};
    assign w_unv = (r_job.visits == 32'd0);

    // leading one of the parent count
    always_comb begin
        w_k = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (r_job.parent[i]) w_k = 5'(i);
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_valid) n_st = S_LNK;
            S_LNK: n_st = S_LNSQ;
            S_LNSQ: if (r_cnt == 6'd15) n_st = S_LNMUL;
            S_LNMUL: n_st = S_DIV1;
            S_DIV1: if (r_cnt == 6'd47) n_st = S_DIV2;
            S_DIV2: if (r_cnt == 6'd47) n_st = S_SQRT;
            S_SQRT: if (r_cnt == 6'd23) n_st = S_MUL;
            S_MUL: n_st = S_CMP;
            S_CMP: n_st = r_job.last ? S_OUT : S_IDLE;
            S_OUT: if (!r_ovalid) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_comb begin
        w_ckey = '0;
        if (r_job.mode == MODE_UCT) begin
            if (r_inf) w_ckey = '0;
            else if (w_unv) w_ckey = KEY_PLUS_INF;
            else w_ckey = {2'b0, r_ratio} + {10'd0, w_ex[39:12]} + 1'b1;
        end else if (r_job.mode == MODE_RATIO) begin
            w_ckey = w_unv ? '0 : ({2'b0, r_ratio} + 1'b1);
        end else begin
            w_ckey = {18'd0, r_job.visits} + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: if (i_valid) begin
                r_job <= i_job;
                r_cnt <= '0;
            end
            S_LNK: begin
                r_k <= w_k;
                r_x <= {1'b0, r_job.parent} << (5'd31 - w_k);
                r_frac <= '0;
            end
            S_LNSQ: begin
                r_cnt <= (r_cnt == 6'd15) ? 6'd0 : r_cnt + 1'b1;
                r_frac <= {r_frac[14:0], w_xn[32]};
                r_x <= w_xn[32] ? {1'b0, w_xn[32:1]} : w_xn;
            end
            S_LNMUL: begin
                if (r_job.first)
                    r_ln <= (r_job.parent <= 32'd1) ? 32'd0 : {11'd0, w_lnp[36:16]};
                r_num <= {r_job.score, 16'd0};
                r_rem <= '0;
            end
            S_DIV1, S_DIV2: begin
                r_cnt <= (r_cnt == 6'd47) ? 6'd0 : r_cnt + 1'b1;
                if (r_cnt == 6'd47) begin
                    r_rem <= '0;
                    if (r_st == S_DIV1) begin
                        r_ratio <= {r_q[46:0], ~w_rs[33]};
                        r_num <= {r_ln, 16'd0};
                    end else begin
                        r_sv <= {r_q[46:0], ~w_rs[33]};
                        r_root <= '0;
                        r_sacc <= '0;
                    end
                end else begin
                    r_num <= {r_num[46:0], 1'b0};
                    if (!w_rs[33]) begin
                        r_rem <= w_rs[32:0];
                        r_q <= {r_q[46:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[31:0], r_num[47]};
                        r_q <= {r_q[46:0], 1'b0};
                    end
                end
            end
            S_SQRT: begin
                r_cnt <= r_cnt + 1'b1;
                r_sv <= {r_sv[45:0], 2'b00};
                if (!w_trial[49]) begin
                    r_sacc <= w_trial;
                    r_root <= {r_root[22:0], 1'b1};
                end else begin
                    r_sacc <= {r_sacc[47:0], r_sv[47:46]};
                    r_root <= {r_root[22:0], 1'b0};
                end
            end
            S_MUL: r_key <= w_ckey;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_best <= '0;
            r_bpos <= '0;
            r_bunv <= 1'b0;
            r_inf <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == S_CMP) begin
                if (r_job.scored && r_key > r_best) begin
                    r_best <= r_key;
                    r_bpos <= r_job.pos;
                    r_bunv <= w_unv;
                    if (r_key == KEY_PLUS_INF) r_inf <= 1'b1;
                end else if (r_job.scored && r_job.first) begin
                    r_bunv <= w_unv;
                end
            end
            // result register loads only once the previous result is gone
            if (r_st == S_OUT && !r_ovalid) begin
                r_ovalid <= 1'b1;
                r_out.chosen_index <= r_bpos;
                r_out.chosen_unvisited <= r_bunv;
                r_best <= '0;
                r_bpos <= '0;
                r_bunv <= 1'b0;
                r_inf <= 1'b0;
            end else if (r_ovalid && i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/uct_child_select.sv */
// Top level of the UCT child selector.
`default_nettype none
// Picks one child of a search-tree node. Children arrive one item each; the
// item with last_child set ends the run and yields one result with the chosen
// position. Modes: UCT score, win ratio, or visit count. The front latches
// side and position and queues the item; the back runs a shared iterative
// datapath: 16 squaring steps for log2, two 48-step restoring divides and a
// 24-step square root. Per item the back takes the item, finds the leading
// one, squares, does the ln multiply, both divides and the square root, forms
// the key and compares; after the last item it loads the result register.
// That load waits while an older result is still unread; meanwhile items of
// the next run fill only the two-entry queue, then full is raised. Configure
// only while idle.
module uct_child_select (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire ucs_pkg::t_in_item  i_item,
    output logic                    empty,
    input  wire logic               pop,
    output ucs_pkg::t_out_item      o_item,
    input  wire logic               i_cfg_we,
    input  wire logic [0:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data
);
    import ucs_pkg::*;
    logic [1:0]  r_mode;
    logic [15:0] r_gain;
    t_job        w_fjob, w_bjob;
    logic        w_fv, w_fr, w_bv, w_br;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_UCT;
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_MODE) r_mode <= i_cfg_data[1:0];
            else if (i_cfg_idx == REG_GAIN) r_gain <= i_cfg_data;
        end
    end

    ucs_front u_front (.i_clk, .i_rst_n, .i_item, .i_push(push), .o_full(full),
        .i_mode(r_mode), .o_job(w_fjob), .o_job_valid(w_fv), .i_job_ready(w_fr));

    ucs_queue u_queue (.i_clk, .i_rst_n, .i_job(w_fjob), .i_valid(w_fv), .o_ready(w_fr),
        .o_job(w_bjob), .o_valid(w_bv), .i_ready(w_br));

    ucs_back u_back (.i_clk, .i_rst_n, .i_job(w_bjob), .i_valid(w_bv), .o_ready(w_br),
        .i_gain(r_gain), .o_item, .o_empty(empty), .i_pop(pop));
endmodule
`default_nettype wire

/* rtl/ucs_checker.sv */
// Port-level checker for the UCT child selector, with its bind.
`default_nettype none
module ucs_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              full,
    input wire logic              empty,
    input wire logic              pop,
    input wire ucs_pkg::t_out_item o_item
);
    a_empty_rst: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_item)))
        else $error("result dropped");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop) |=> empty)
        else $error("result repeated");
    a_full_rst: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("full after reset");
endmodule

bind uct_child_select ucs_checker u_chk (.i_clk, .i_rst_n, .full, .empty,
    .pop, .o_item);
`default_nettype wire

/* dv/tb_uct_child_select.sv */
// Testbench for uct_child_select: directed table plus random runs, self-checked.
`default_nettype none
module tb_uct_child_select;
    timeunit 1ns;
    timeprecision 1ps;
    import ucs_pkg::*;

    // Modes the package does not name.
    localparam logic [1:0] MODE_VISITS = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         IDLE_LIMIT  = 20000;
    localparam int         BACK_CYCLES = 150;   // per-item cost in the back end, rounded up
    localparam int         HOLD_CYCLES = 800;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    t_in_item   i_item = '0;
    logic       empty;
    logic       pop = 1'b0;
    t_out_item  o_item;
    logic       i_cfg_we = 1'b0;
    logic [0:0] i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    uct_child_select i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_item(o_item),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Shadow of the block: configuration and run state.
    logic [1:0]  cur_mode = MODE_UCT;
    logic [15:0] cur_gain = GAIN_RESET;
    logic [63:0] best_key = '0;
    int          best_pos = 0;
    int          child_pos = 0;
    logic [31:0] run_ln = '0;
    logic        run_side = 1'b0;
    logic        saw_inf = 1'b0;
    logic        best_unv = 1'b0;

    t_out_item   pending_choices[$];
    int          items_in_run = 0;      // items accepted since the last run ended
    int          errors = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    bit          want_hold = 0;
    bit          hold_done = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    // Natural log in Q16.16 via log2 by repeated squaring.
    function automatic logic [31:0] ln_fix(logic [31:0] p);
        int          k;
        logic [63:0] x;
        logic [15:0] frac;
        logic [63:0] l2;
        if (p <= 32'd1) return '0;
        k = 31;
        while (!p[k]) k--;
        x = {32'b0, p} << (31 - k);
        frac = '0;
        for (int i = 0; i < 16; i++) begin
            x = (x * x) >> 31;
            frac = frac << 1;
            if (x >= 64'h1_0000_0000) begin
                frac[0] = 1'b1;
                x = x >> 1;
            end
        end
        l2 = (64'(k) << 16) | 64'(frac);
        return 32'((l2 * 64'(LN2_Q16)) >> 16);
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // Score one child; returns 1 with the choice when the run ends.
    task automatic choose_child(input t_in_item it, output bit done, output t_out_item res);
        logic [63:0] score, visits, key, ratio, expl;
        done = 0;
        res = '0;
        if (child_pos == 0) begin
            run_side = it.side;
            run_ln = ln_fix(it.parent_visits);
        end
        if (child_pos < MAX_CHILDREN) begin
            score = run_side ? 64'(it.child_score_side1) : 64'(it.child_score_side0);
            visits = 64'(it.child_visits);
            if (cur_mode == MODE_UCT) begin
                if (saw_inf) key = '0;
                else if (visits == 0) key = 64'(KEY_PLUS_INF);
                else begin
                    ratio = (score << 16) / visits;
                    expl = (64'(cur_gain) * isqrt((64'(run_ln) << 16) / visits)) >> 12;
                    key = (ratio + expl + 64'd1) & 64'(KEY_PLUS_INF);
                end
            end else if (cur_mode == MODE_RATIO) begin
                key = (visits == 0) ? 64'd0 : ((score << 16) / visits) + 64'd1;
            end else begin
                key = visits + 64'd1;
            end
            if (key > best_key) begin
                best_key = key;
                best_pos = child_pos;
                best_unv = (visits == 0);
                if (key == 64'(KEY_PLUS_INF)) saw_inf = 1'b1;
            end else if (child_pos == 0) begin
                best_unv = (visits == 0);
            end
        end
        if (it.last_child) begin
            done = 1;
            res.chosen_index = 8'(best_pos);
            res.chosen_unvisited = best_unv;
            best_key = '0; best_pos = 0; child_pos = 0; run_ln = '0;
            run_side = 1'b0; saw_inf = 1'b0; best_unv = 1'b0;
        end else if (child_pos < MAX_CHILDREN) begin
            child_pos++;
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Offer one item, wait for acceptance, then book its expected choice.
    // A typed expectation, when given, replaces the predicted one.
    task automatic send_item(t_in_item it, bit typed = 0, t_out_item want = '0);
        bit        done;
        t_out_item res;
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        choose_child(it, done, res);
        items_in_run++;
        if (done) begin
            pending_choices.push_back(typed ? want : res);
            items_in_run = 0;
        end
    endtask

    // Register write while idle: drain results, then let unfinished items settle.
    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_choices.size() != 0) @(posedge i_clk);
        repeat (BACK_CYCLES * items_in_run + 20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_MODE) cur_mode = val[1:0];
        else cur_gain = val;
    endtask

    function automatic t_in_item make_child(logic [31:0] parent, logic side,
                                            logic [31:0] s0, logic [31:0] s1,
                                            logic [31:0] v, logic last);
        t_in_item it;
        it.side = side;
        it.parent_visits = parent;
        it.child_score_side0 = s0;
        it.child_score_side1 = s1;
        it.child_visits = v;
        it.last_child = last;
        return it;
    endfunction

    // Random child: mostly plausible statistics, some full-range noise and ties.
    function automatic t_in_item rand_child(t_in_item prev, logic last);
        t_in_item it;
        it.side = 1'($urandom);
        it.parent_visits = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 100000);
        case ($urandom_range(9))
            0:       it.child_visits = '0;
            1:       it.child_visits = $urandom;
            default: it.child_visits = $urandom_range(1, 5000);
        endcase
        it.child_score_side0 = ($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 10000);
        it.child_score_side1 = ($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 10000);
        if ($urandom_range(9) == 0) begin
            it.child_visits = prev.child_visits;
            it.child_score_side0 = prev.child_score_side0;
            it.child_score_side1 = prev.child_score_side1;
        end
        it.last_child = last;
        return it;
    endfunction

    task automatic random_run(int n);
        t_in_item it;
        it = '0;
        for (int i = 0; i < n; i++) begin
            it = rand_child(it, i == n - 1);
            send_item(it);
        end
    endtask

    // Result side: check each accepted choice, stall at random, and hold off
    // once for a long stretch when asked so the block backs up into its input.
    always @(posedge i_clk) begin
        t_out_item want;
        if (pop && !empty) begin
            if (pending_choices.size() == 0) begin
                $display("%0t unexpected result index %0d", $realtime, o_item.chosen_index);
                errors++;
            end else begin
                want = pending_choices.pop_front();
                if (o_item.chosen_index !== want.chosen_index)
                    report_mismatch("chosen_index", o_item.chosen_index, want.chosen_index);
                if (o_item.chosen_unvisited !== want.chosen_unvisited)
                    report_mismatch("chosen_unvisited", o_item.chosen_unvisited,
                                    want.chosen_unvisited);
            end
        end
        if (want_hold && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1;
        end
        if (hold_left > 0) hold_left--;
        pop <= i_rst_n && hold_left == 0 && ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: ends the run after a long stretch with no handshake.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || i_cfg_we || !i_rst_n) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("uct_child_select regression: fail");
            $finish;
        end
    end

    // Directed table row: mode in force, item, and an optional typed-in choice.
    typedef struct {
        logic [1:0] mode;
        t_in_item   it;
        bit         typed;
        t_out_item  want;
    } t_row;

    t_row rows[$];

    function automatic void add_row(logic [1:0] mode, t_in_item it,
                                    bit typed = 0, logic [7:0] idx = 0, logic unv = 0);
        t_row r;
        r.mode = mode;
        r.it = it;
        r.typed = typed;
        r.want.chosen_index = idx;
        r.want.chosen_unvisited = unv;
        rows.push_back(r);
    endfunction

    initial begin
        logic [15:0] gains[4];
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Straight after reset: UCT, lone unvisited child.
        add_row(MODE_UCT, make_child(0, 0, 0, 0, 0, 1), 1, 0, 1);
        // Ratio mode, nobody visited: all minus infinity, first child wins.
        add_row(MODE_RATIO, make_child(50, 0, 9, 9, 0, 0));
        add_row(MODE_RATIO, make_child(50, 0, 3, 3, 0, 0));
        add_row(MODE_RATIO, make_child(50, 0, 7, 7, 0, 1), 1, 0, 1);
        // Visit count, tie at the top keeps the earlier child.
        add_row(MODE_VISITS, make_child(9, 0, 0, 0, 5, 0));
        add_row(MODE_VISITS, make_child(9, 0, 0, 0, 32'hFFFF_FFFF, 0));
        add_row(MODE_VISITS, make_child(9, 0, 0, 0, 32'hFFFF_FFFF, 1), 1, 1, 0);
        // Spare mode code behaves as visit count.
        add_row(MODE_SPARE, make_child(9, 1, 0, 0, 0, 0));
        add_row(MODE_SPARE, make_child(9, 1, 0, 0, 7, 1), 1, 1, 0);
        // UCT: first unvisited child is infinite, later ones get key zero.
        add_row(MODE_UCT, make_child(20, 0, 10, 0, 10, 0));
        add_row(MODE_UCT, make_child(20, 0, 0, 0, 0, 0));
        add_row(MODE_UCT, make_child(20, 0, 0, 0, 0, 1), 1, 1, 1);
        // UCT extremes of every field.
        add_row(MODE_UCT, make_child(32'hFFFF_FFFF, 1, 0, 32'hFFFF_FFFF, 1, 0));
        add_row(MODE_UCT, make_child(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1));
        // Parent of one: no exploration term.
        add_row(MODE_UCT, make_child(1, 0, 4, 100, 8, 0));
        add_row(MODE_UCT, make_child(1, 1, 5, 1, 8, 1));
        // Mode switched between children of one run.
        add_row(MODE_UCT, make_child(100, 0, 1, 0, 3, 0));
        add_row(MODE_RATIO, make_child(100, 1, 32'hFFFF_FFFF, 2, 1, 0));
        add_row(MODE_VISITS, make_child(7, 1, 0, 0, 2, 1));
        // Ratio with side one latched from the first child.
        add_row(MODE_RATIO, make_child(30, 1, 1, 9, 10, 0));
        add_row(MODE_RATIO, make_child(30, 0, 9, 3, 10, 1));

        foreach (rows[i]) begin
            if (rows[i].mode != cur_mode) write_reg(REG_MODE, {14'b0, rows[i].mode});
            send_item(rows[i].it, rows[i].typed, rows[i].want);
        end

        // Random part in four idling phases, each with its own settings.
        gains = '{16'd0, 16'hFFFF, 16'($urandom), GAIN_RESET};
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 48; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 48; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            write_reg(REG_GAIN, gains[ph]);
            write_reg(REG_MODE, 16'(ph % 3));
            // Long hold-off on results while single-child runs keep coming.
            if (ph == 0) begin
                want_hold = 1;
                repeat (20) random_run(1);
            end
            // Oversized run, once, to reach the position limit.
            if (ph == 1) random_run(MAX_CHILDREN + 4);
            for (int n = 0; n < 25; ) begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 6);
                random_run(len);
                n += len;
                if ($urandom_range(11) == 0) write_reg(REG_MODE, 16'($urandom_range(0, 3)));
                if ($urandom_range(15) == 0) write_reg(REG_GAIN, 16'($urandom));
            end
        end

        push <= 1'b0;
        while (pending_choices.size() != 0) @(posedge i_clk);
        repeat (2 * BACK_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("uct_child_select regression: pass");
        end else begin
            $display("uct_child_select regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
rtl/ucs_pkg.sv
rtl/ucs_front.sv
rtl/ucs_queue.sv
rtl/ucs_back.sv
rtl/uct_child_select.sv
rtl/ucs_checker.sv
dv/tb_uct_child_select.sv
